@@ rtl/lfu_pkg.sv @@
// Shared types, constants and the control store of the LFU slot table.
package lfu_pkg;

  localparam int SLOTS    = 16;
  localparam int KEY_BITS = 8;
  localparam int CNT_W    = 16;
  localparam int STAMP_W  = 32;
  localparam int CFG_W    = 5;
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FILL_W   = $clog2(SLOTS + 1);
  localparam int LIM_W    = (FILL_W > CFG_W) ? FILL_W : CFG_W;
  localparam int STEP_W   = 2;
  localparam int OUT_W    = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  localparam logic [STEP_W-1:0] STEP_WAIT   = 2'd0;
  localparam logic [STEP_W-1:0] STEP_SCAN   = 2'd1;
  localparam logic [STEP_W-1:0] STEP_COMMIT = 2'd2;

  typedef enum logic [1:0] {
    COND_IN_ACC   = 2'd0,
    COND_SCAN_END = 2'd1,
    COND_OUT_FREE = 2'd2
  } cond_t;

  typedef struct packed {
    logic wait_in;
    logic scan;
    logic commit;
  } ctrl_t;

  typedef struct packed {
    logic in_acc;
    logic scan_end;
    logic out_free;
  } status_t;

  typedef struct packed {
    cond_t              cond;
    logic [STEP_W-1:0]  target;
    ctrl_t              ctrl;
  } uword_t;

  // Each step holds until its condition is true, then branches to its target.
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{cond: COND_IN_ACC, target: STEP_WAIT, ctrl: '{wait_in: 1'b0, scan: 1'b0,
          commit: 1'b0}};
    unique case (step)
      STEP_WAIT: begin
        w = '{cond: COND_IN_ACC, target: STEP_SCAN,
              ctrl: '{wait_in: 1'b1, scan: 1'b0, commit: 1'b0}};
      end
      STEP_SCAN: begin
        w = '{cond: COND_SCAN_END, target: STEP_COMMIT,
              ctrl: '{wait_in: 1'b0, scan: 1'b1, commit: 1'b0}};
      end
      STEP_COMMIT: begin
        w = '{cond: COND_OUT_FREE, target: STEP_WAIT,
              ctrl: '{wait_in: 1'b0, scan: 1'b0, commit: 1'b1}};
      end
      default: begin
        w = '{cond: COND_IN_ACC, target: STEP_WAIT,
              ctrl: '{wait_in: 1'b0, scan: 1'b0, commit: 1'b0}};
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/lfu_slot_table_fifo_tiebreak.sv @@
// Top level of the LFU slot table with FIFO tie-break.
//
// Each request on the in_ channel carries one key reference. The block looks
// the key up among the filled slots; a hit raises that slot's count, a miss
// takes the next free slot or, once the active limit is reached, replaces
// the slot with the lowest count and, among equal counts, the oldest stamp.
// One result per request leaves on the out_ channel.
// A request is taken in the wait step; the scan step then reads the filled
// slots, at most 16, one slot at a time until it sees the end of the scan,
// and the commit step loads the result register.
// The result register is loaded at the end and the next request can be taken
// in the following cycle, even while that result still waits.
// If the receiver stalls, the block holds in its commit step until the
// result register frees up; nothing is dropped.
// The cfg_ port sets the active slot count, always ready; write it only
// while idle. Reset empties the table, clears the reference clock and sets
// the active slot count to 16.
module lfu_slot_table_fifo_tiebreak (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lfu_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lfu_pkg::KEY_BITS-1:0]  in_tdata,   // key
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lfu_pkg::OUT_W-1:0]     out_tdata   // slot, hit, evicted_valid,
                                                    // evicted_key, new_count, zero
);
  import lfu_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  lfu_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  lfu_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl_i     (ctrl),
    .status_o   (status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_key     (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ rtl/lfu_seq.sv @@
// Microcode sequencer: step counter, control store lookup and branching.
module lfu_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  lfu_pkg::status_t status_i,
  output lfu_pkg::ctrl_t   ctrl_o
);
  import lfu_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  uword_t            word;
  logic              cond_true;

  assign word   = ucode(step_r);
  assign ctrl_o = word.ctrl;

  always_comb begin
    case (word.cond)
      COND_IN_ACC:   cond_true = status_i.in_acc;
      COND_SCAN_END: cond_true = status_i.scan_end;
      COND_OUT_FREE: cond_true = status_i.out_free;
      default:       cond_true = 1'b1;
    endcase
    step_nxt = cond_true ? word.target : step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    step_r == STEP_WAIT || step_r == STEP_SCAN || step_r == STEP_COMMIT)
    else $error("sequencer left its program");

  assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == STEP_COMMIT && status_i.out_free) |=> step_r == STEP_WAIT)
    else $error("commit step did not return to wait");

  assert property (@(posedge clk) disable iff (!rst_n)
    status_i.in_acc |-> ctrl_o.wait_in)
    else $error("request taken outside the wait step");

endmodule

@@ rtl/lfu_dpath.sv @@
// Datapath: slot arrays, scan registers, commit logic and result register.
module lfu_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lfu_pkg::ctrl_t              ctrl_i,
  output lfu_pkg::status_t            status_o,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lfu_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [lfu_pkg::KEY_BITS-1:0] in_key,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [lfu_pkg::OUT_W-1:0]   out_tdata
);
  import lfu_pkg::*;

  logic [KEY_BITS-1:0] slot_key_r   [SLOTS];
  logic [CNT_W-1:0]    slot_count_r [SLOTS];
  logic [STAMP_W-1:0]  slot_stamp_r [SLOTS];

  logic [CFG_W-1:0]    active_r;
  logic [FILL_W-1:0]   filled_r;
  logic [STAMP_W-1:0]  clock_r;
  logic [KEY_BITS-1:0] key_r;
  logic [FILL_W-1:0]   idx_r;
  logic                found_r;
  logic [IDX_W-1:0]    hit_pos_r;
  logic [CNT_W-1:0]    hit_cnt_r;
  logic [IDX_W-1:0]    best_idx_r;
  logic [CNT_W-1:0]    best_cnt_r;
  logic [STAMP_W-1:0]  best_stamp_r;
  logic [KEY_BITS-1:0] best_key_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;

  logic                in_acc;
  logic                scan_end;
  logic                out_free;
  logic                scan_en;
  logic                commit_en;
  logic [IDX_W-1:0]    sidx;
  logic [KEY_BITS-1:0] e_key;
  logic [CNT_W-1:0]    e_cnt;
  logic [STAMP_W-1:0]  e_stamp;
  logic                better;
  logic [LIM_W-1:0]    act_ext;
  logic [LIM_W-1:0]    lim;
  logic                has_room;
  logic [IDX_W-1:0]    c_pos;
  logic [CNT_W-1:0]    c_cnt;
  logic                c_ev;
  logic [KEY_BITS-1:0] c_ev_key;

  assign cfg_ready  = 1'b1;
  assign in_tready  = ctrl_i.wait_in;
  assign in_acc     = in_tvalid && in_tready;
  assign scan_end   = (idx_r == filled_r);
  assign out_free   = !out_valid_r || out_tready;
  assign scan_en    = ctrl_i.scan && !scan_end;
  assign commit_en  = ctrl_i.commit && out_free;
  assign status_o   = '{in_acc: in_acc, scan_end: scan_end, out_free: out_free};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sidx    = idx_r[IDX_W-1:0];
  assign e_key   = slot_key_r[sidx];
  assign e_cnt   = slot_count_r[sidx];
  assign e_stamp = slot_stamp_r[sidx];
  assign better  = (idx_r == '0) || (e_cnt < best_cnt_r) ||
                   (e_cnt == best_cnt_r && e_stamp < best_stamp_r);

  always_comb begin
    act_ext = LIM_W'(active_r);
    if (act_ext == '0) begin
      lim = LIM_W'(1);
    end else if (act_ext > LIM_W'(SLOTS)) begin
      lim = LIM_W'(SLOTS);
    end else begin
      lim = act_ext;
    end
    has_room = LIM_W'(filled_r) < lim;
    c_ev     = 1'b0;
    c_ev_key = '0;
    if (found_r) begin
      c_pos = hit_pos_r;
      c_cnt = (hit_cnt_r == CNT_MAX) ? hit_cnt_r : hit_cnt_r + CNT_W'(1);
    end else if (has_room) begin
      c_pos = filled_r[IDX_W-1:0];
      c_cnt = CNT_W'(1);
    end else begin
      c_pos    = best_idx_r;
      c_cnt    = CNT_W'(1);
      c_ev     = 1'b1;
      c_ev_key = best_key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= CFG_RESET;
      filled_r    <= '0;
      clock_r     <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_data;
      end
      if (in_acc) begin
        clock_r <= clock_r + STAMP_W'(1);
        idx_r   <= '0;
        found_r <= 1'b0;
      end
      if (scan_en) begin
        idx_r <= idx_r + FILL_W'(1);
        if (!found_r && e_key == key_r) begin
          found_r <= 1'b1;
        end
      end
      if (commit_en) begin
        out_valid_r <= 1'b1;
        if (!found_r && has_room) begin
          filled_r <= filled_r + FILL_W'(1);
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r <= in_key;
    end
    if (scan_en) begin
      if (!found_r && e_key == key_r) begin
        hit_pos_r <= sidx;
        hit_cnt_r <= e_cnt;
      end
      if (better) begin
        best_idx_r   <= sidx;
        best_cnt_r   <= e_cnt;
        best_stamp_r <= e_stamp;
        best_key_r   <= e_key;
      end
    end
    if (commit_en) begin
      slot_count_r[c_pos] <= c_cnt;
      if (!found_r) begin
        slot_key_r[c_pos]   <= key_r;
        slot_stamp_r[c_pos] <= clock_r;
      end
      out_data_r <= {2'b00, c_cnt, c_ev_key, c_ev, found_r, c_pos};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= filled_r && filled_r <= FILL_W'(SLOTS))
    else $error("scan index or fill count out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    commit_en |=> out_valid_r)
    else $error("committed result not presented");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> idx_r == '0 && !found_r)
    else $error("scan not restarted for new request");

  assert property (@(posedge clk) disable iff (!rst_n)
    (commit_en && !found_r && has_room) |=> filled_r == $past(filled_r) + FILL_W'(1))
    else $error("fill count not advanced on free-slot placement");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the LFU slot table with FIFO tie-break.
module tb_top;
  import lfu_pkg::*;

  localparam int unsigned RUN_LIMIT = 200000;

  typedef struct packed {
    logic [CNT_W-1:0]    count;
    logic [KEY_BITS-1:0] ev_key;
    logic                ev_valid;
    logic                hit;
    logic [IDX_W-1:0]    slot;
  } lfu_result_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data;
  logic                in_tvalid;
  logic                in_tready;
  logic [KEY_BITS-1:0] in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_W-1:0]    out_tdata;

  lfu_slot_table_fifo_tiebreak u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Predicted table contents and the active slot limit.
  logic [KEY_BITS-1:0] tbl_key   [SLOTS];
  logic [CNT_W-1:0]    tbl_count [SLOTS];
  logic [STAMP_W-1:0]  tbl_stamp [SLOTS];
  int unsigned         tbl_filled;
  logic [STAMP_W-1:0]  ref_num;
  logic [CFG_W-1:0]    active_limit;

  lfu_result_t  pending_results[$];
  int unsigned  mismatches;
  int unsigned  cycle_count;
  int           hold_cycles;
  bit           idle_on;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic lfu_result_t lfu_predict(input logic [KEY_BITS-1:0] k);
    lfu_result_t r;
    int unsigned n;
    int unsigned lim;
    int unsigned pos;
    bit          found;
    r = '0;
    n = tbl_filled;
    pos = 0;
    found = 1'b0;
    ref_num = ref_num + STAMP_W'(1);
    lim = 32'(active_limit);
    if (lim < 1) lim = 1;
    if (lim > SLOTS) lim = SLOTS;
    for (int i = 0; i < n; i++) begin
      if (!found && tbl_key[i] == k) begin
        found = 1'b1;
        pos = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (tbl_count[pos] != CNT_MAX) tbl_count[pos] = tbl_count[pos] + CNT_W'(1);
    end else begin
      if (n < lim) begin
        pos = n;
        tbl_filled = n + 1;
      end else begin
        pos = 0;
        for (int i = 1; i < n; i++) begin
          if (tbl_count[i] < tbl_count[pos] ||
              (tbl_count[i] == tbl_count[pos] && tbl_stamp[i] < tbl_stamp[pos])) begin
            pos = i;
          end
        end
        r.ev_valid = 1'b1;
        r.ev_key = tbl_key[pos];
      end
      tbl_key[pos] = k;
      tbl_count[pos] = CNT_W'(1);
      tbl_stamp[pos] = ref_num;
    end
    r.slot = pos[IDX_W-1:0];
    r.count = tbl_count[pos];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s expected %0h, got %0h", $realtime, name, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin
    lfu_result_t seen;
    lfu_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = lfu_result_t'(out_tdata[29:0]);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result %0h arrived with no request pending", $realtime, out_tdata);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("slot", 32'(want.slot), 32'(seen.slot));
        check_field("hit", 32'(want.hit), 32'(seen.hit));
        check_field("evicted_valid", 32'(want.ev_valid), 32'(seen.ev_valid));
        check_field("evicted_key", 32'(want.ev_key), 32'(seen.ev_key));
        check_field("new_count", 32'(want.count), 32'(seen.count));
        check_field("padding", 32'd0, 32'(out_tdata[OUT_W-1:30]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The receiver stalls in random bursts, or for a long stretch on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_ref(input logic [KEY_BITS-1:0] k);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= k;
    do @(posedge clk); while (!in_tready);
    pending_results = {pending_results, lfu_predict(k)};
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    active_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_random_refs(input int unsigned count, input int unsigned pool_size);
    logic [KEY_BITS-1:0] pool[$];
    int unsigned         pick;
    for (int i = 0; i < pool_size; i++) pool = {pool, KEY_BITS'($urandom_range(0, 255))};
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 1) == 0) pick = $urandom_range(0, (pool_size - 1) / 4);
        else pick = $urandom_range(0, pool_size - 1);
        send_ref(pool[pick]);
      end else begin
        send_ref(KEY_BITS'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_repeated_hits();
    idle_on = 1'b0;
    write_limit(5'd1);
    for (int i = 0; i < 40; i++) send_ref(8'hA5);
    drain_results();
    idle_on = 1'b1;
  endtask

  task automatic test_limit_zero();
    write_limit(5'd0);
    send_ref(8'h00);
    send_ref(8'hFF);
    send_ref(8'hFF);
    drain_results();
  endtask

  task automatic test_small_limits();
    write_limit(5'd5);
    send_random_refs(120, 8);
    drain_results();
    write_limit(5'd10);
    send_random_refs(120, 14);
    drain_results();
  endtask

  task automatic test_limit_above_slots();
    logic [KEY_BITS-1:0] fill_keys[12] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
                                           8'h40, 8'h80, 8'h7F, 8'hBF, 8'hDF, 8'hFE};
    write_limit(5'd31);
    foreach (fill_keys[i]) send_ref(fill_keys[i]);
    send_ref(8'h01);
    send_ref(8'h55);
    send_ref(8'hAA);
    send_ref(8'h33);
    drain_results();
  endtask

  task automatic test_limit_below_filled();
    write_limit(5'd3);
    send_random_refs(150, 24);
    drain_results();
  endtask

  task automatic test_output_backpressure();
    write_limit(5'd16);
    hold_cycles = 300;
    send_random_refs(12, 20);
    drain_results();
    send_random_refs(60, 20);
    drain_results();
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    send_random_refs(100, 22);
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    mismatches = 0;
    cycle_count = 0;
    hold_cycles = 0;
    idle_on = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_key[i] = '0;
      tbl_count[i] = '0;
      tbl_stamp[i] = '0;
    end
    tbl_filled = 0;
    ref_num = '0;
    active_limit = CFG_RESET;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_repeated_hits();
    test_limit_zero();
    test_small_limits();
    test_limit_above_slots();
    test_limit_below_filled();
    test_output_backpressure();
    test_steady_stream();

    repeat (40) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
